// ===== rtl/core/sds_pkg.sv =====
// Shared types and constants for the stroke dab spacing block.
// Used by sds_serial_unit and stroke_dab_spacing; depends on nothing.
`default_nettype none

package sds_pkg;

   localparam int COORD_BITS    = 20;
   localparam int PRESS_BITS    = 16;
   localparam int DIST_BITS     = 24;
   localparam int STEP_BITS     = 16;
   localparam int CFG_BITS      = 16;
   localparam int CSR_ADDR_BITS = 8;
   localparam int SUM_BITS      = 41;
   localparam int ROOT_BITS     = 21;
   localparam int MAX_DABS_DEF  = 64;

   localparam logic [CFG_BITS-1:0]      RADIUS_RESET  = 16'd2048;
   localparam logic [CFG_BITS-1:0]      SPACING_RESET = 16'd13107;
   localparam logic [DIST_BITS-1:0]     DIST_MAX      = 24'hFFFFFF;
   localparam logic [CSR_ADDR_BITS-1:0] REG_RADIUS    = 8'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_SPACING   = 8'd1;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_SQRT,
      OP_MULDIV
   } sds_op_type;

   typedef struct packed {
      logic       start;
      sds_op_type op;
   } sds_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_ROOT,
      ST_STEP,
      ST_CHECK,
      ST_MX,
      ST_MY,
      ST_MP,
      ST_EMIT
   } sds_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/stroke_dab_spacing.sv =====
// Stroke dab spacing: top level. Depends on sds_pkg and sds_serial_unit.
// Sequences the serial arithmetic that turns pen samples into dabs.
//
// Each pen sample transfer on req_ adds the distance from the previous sample
// to a pending-distance accumulator and then emits evenly spaced dabs on rsp_,
// one transfer per dab, at most MAX_DABS per sample, the final one marked by
// rsp_tlast and, when distance is still pending after the cap, rsp_tuser.
// One sample is worked on at a time. All arithmetic runs through one
// bit-serial unit: the distance takes two squares, a square root and a step
// product, and each dab three more multiply-and-divide passes, one per
// coordinate and pressure, a check state and an output state that waits
// for the consumer to accept it. A sample that causes no dab returns to
// idle after the distance steps and the check. Configuration writes on
// csr_ are taken at any time and are meant to happen while the block is idle.
`default_nettype none

module stroke_dab_spacing #(
   parameter int MAX_DABS = sds_pkg::MAX_DABS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: pointer_x[19:0], pointer_y[39:20], pen_pressure[55:40]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [55:0]                       req_tdata,
   // tdata: dab_x[19:0], dab_y[39:20], dab_opacity[53:40], zero fill[55:54]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [55:0]                       rsp_tdata,
   output logic                              rsp_tlast,
   // tuser: capped[0]
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sds_pkg::CSR_ADDR_BITS-1:0] csr_index,
   input  logic [sds_pkg::CFG_BITS-1:0]      csr_data
);

   localparam int CNT_W = $clog2(MAX_DABS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DABS);

   sds_pkg::sds_state_type state_ff, state_in;
   logic first_ff, first_in;

   // architectural state
   logic [19:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [19:0] paint_x_ff, paint_x_in, paint_y_ff, paint_y_in;
   logic [15:0] paint_p_ff, paint_p_in;
   logic [23:0] trav_ff, trav_in;
   logic [15:0] radius_ff, radius_in, spacing_ff, spacing_in;

   // per-sample working registers
   logic [19:0] x_ff, x_in, y_ff, y_in;
   logic [15:0] p_ff, p_in;
   logic [40:0] sum_ff, sum_in;
   logic [23:0] dist_ff, dist_in;
   logic [15:0] step_ff, step_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic last_ff, last_in, capped_ff, capped_in;

   sds_pkg::sds_cmd_type cmd;
   logic [40:0] arg_a;
   logic [19:0] arg_b;
   logic        unit_done;
   logic [40:0] unit_res;

   logic [19:0] dx, dy, mag_x, mag_y;
   logic [15:0] mag_p;
   logic        up_x, up_y, up_p;
   logic        more;

   sds_serial_unit u_unit (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .arg_a   (arg_a),
      .arg_b   (arg_b),
      .arg_den (dist_ff),
      .done    (unit_done),
      .result  (unit_res)
   );

   // absolute differences and directions
   assign dx    = (x_ff >= prev_x_ff) ? x_ff - prev_x_ff : prev_x_ff - x_ff;
   assign dy    = (y_ff >= prev_y_ff) ? y_ff - prev_y_ff : prev_y_ff - y_ff;
   assign up_x  = x_ff >= paint_x_ff;
   assign up_y  = y_ff >= paint_y_ff;
   assign up_p  = p_ff >= paint_p_ff;
   assign mag_x = up_x ? x_ff - paint_x_ff : paint_x_ff - x_ff;
   assign mag_y = up_y ? y_ff - paint_y_ff : paint_y_ff - y_ff;
   assign mag_p = up_p ? p_ff - paint_p_ff : paint_p_ff - p_ff;
   // another dab is due while distance covers a step and the cap allows
   assign more  = (dist_ff >= {8'd0, step_ff}) && (n_ff < CNT_MAX);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sds_pkg::ST_IDLE:  if (req_tvalid) state_in = sds_pkg::ST_SQX;
         sds_pkg::ST_SQX:   if (unit_done) state_in = sds_pkg::ST_SQY;
         sds_pkg::ST_SQY:   if (unit_done) state_in = sds_pkg::ST_ROOT;
         sds_pkg::ST_ROOT:  if (unit_done) state_in = sds_pkg::ST_STEP;
         sds_pkg::ST_STEP:  if (unit_done) state_in = sds_pkg::ST_CHECK;
         sds_pkg::ST_CHECK: state_in = more ? sds_pkg::ST_MX : sds_pkg::ST_IDLE;
         sds_pkg::ST_MX:    if (unit_done) state_in = sds_pkg::ST_MY;
         sds_pkg::ST_MY:    if (unit_done) state_in = sds_pkg::ST_MP;
         sds_pkg::ST_MP:    if (unit_done) state_in = sds_pkg::ST_EMIT;
         sds_pkg::ST_EMIT:  if (rsp_tready) state_in = sds_pkg::ST_CHECK;
         default:           state_in = sds_pkg::ST_IDLE;
      endcase
   end

   assign first_in = state_in != state_ff;

   // outputs and unit commands
   always_comb begin
      cmd.start  = 1'b0;
      cmd.op     = sds_pkg::OP_MUL;
      arg_a      = '0;
      arg_b      = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         sds_pkg::ST_IDLE: req_tready = 1'b1;
         sds_pkg::ST_SQX: begin
            cmd.start = first_ff;
            arg_a     = {21'd0, dx};
            arg_b     = dx;
         end
         sds_pkg::ST_SQY: begin
            cmd.start = first_ff;
            arg_a     = {21'd0, dy};
            arg_b     = dy;
         end
         sds_pkg::ST_ROOT: begin
            cmd.start = first_ff;
            cmd.op    = sds_pkg::OP_SQRT;
            arg_a     = sum_ff;
         end
         sds_pkg::ST_STEP: begin
            cmd.start = first_ff;
            arg_a     = {25'd0, radius_ff};
            arg_b     = {4'd0, spacing_ff};
         end
         sds_pkg::ST_MX: begin
            cmd.start = first_ff;
            cmd.op    = sds_pkg::OP_MULDIV;
            arg_a     = {21'd0, mag_x};
            arg_b     = {4'd0, step_ff};
         end
         sds_pkg::ST_MY: begin
            cmd.start = first_ff;
            cmd.op    = sds_pkg::OP_MULDIV;
            arg_a     = {21'd0, mag_y};
            arg_b     = {4'd0, step_ff};
         end
         sds_pkg::ST_MP: begin
            cmd.start = first_ff;
            cmd.op    = sds_pkg::OP_MULDIV;
            arg_a     = {25'd0, mag_p};
            arg_b     = {4'd0, step_ff};
         end
         sds_pkg::ST_EMIT: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      logic [24:0] total;
      logic [31:0] rounded;
      logic [23:0] dist_new;
      logic [CNT_W-1:0] n_new;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      paint_x_in = paint_x_ff;
      paint_y_in = paint_y_ff;
      paint_p_in = paint_p_ff;
      trav_in    = trav_ff;
      radius_in  = radius_ff;
      spacing_in = spacing_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      p_in       = p_ff;
      sum_in     = sum_ff;
      dist_in    = dist_ff;
      step_in    = step_ff;
      n_in       = n_ff;
      last_in    = last_ff;
      capped_in  = capped_ff;
      total      = {1'b0, trav_ff} + {4'd0, unit_res[20:0]};
      rounded    = unit_res[31:0] + 32'h8000;
      dist_new   = dist_ff - {8'd0, step_ff};
      n_new      = n_ff + CNT_W'(1);

      // register writes; unknown indices drop
      if (csr_valid) begin
         if (csr_index == sds_pkg::REG_RADIUS)  radius_in  = csr_data;
         if (csr_index == sds_pkg::REG_SPACING) spacing_in = csr_data;
      end

      unique case (state_ff)
         sds_pkg::ST_IDLE: begin
            x_in = req_tdata[19:0];
            y_in = req_tdata[39:20];
            p_in = req_tdata[55:40];
         end
         sds_pkg::ST_SQX: if (unit_done) sum_in = {1'b0, unit_res[39:0]};
         sds_pkg::ST_SQY: if (unit_done) sum_in = sum_ff + unit_res;
         sds_pkg::ST_ROOT: begin
            // saturate the pending distance
            if (unit_done) dist_in = total[24] ? sds_pkg::DIST_MAX : total[23:0];
         end
         sds_pkg::ST_STEP: begin
            if (unit_done) begin
               // a zero step is forced to the smallest step to bound the loop
               step_in = (rounded[31:16] == 16'd0) ? 16'd1 : rounded[31:16];
               n_in    = '0;
            end
         end
         sds_pkg::ST_CHECK: begin
            if (!more) begin
               trav_in   = dist_ff;
               prev_x_in = x_ff;
               prev_y_in = y_ff;
            end
         end
         sds_pkg::ST_MX: begin
            if (unit_done)
               paint_x_in = up_x ? paint_x_ff + unit_res[19:0] : paint_x_ff - unit_res[19:0];
         end
         sds_pkg::ST_MY: begin
            if (unit_done)
               paint_y_in = up_y ? paint_y_ff + unit_res[19:0] : paint_y_ff - unit_res[19:0];
         end
         sds_pkg::ST_MP: begin
            if (unit_done) begin
               paint_p_in = up_p ? paint_p_ff + unit_res[15:0] : paint_p_ff - unit_res[15:0];
               dist_in    = dist_new;
               n_in       = n_new;
               // mark the final dab, and flag distance left behind by the cap
               last_in    = !((dist_new >= {8'd0, step_ff}) && (n_new < CNT_MAX));
               capped_in  = (n_new >= CNT_MAX) && (dist_new >= {8'd0, step_ff});
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sds_pkg::ST_IDLE;
         first_ff   <= 1'b0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         paint_x_ff <= '0;
         paint_y_ff <= '0;
         paint_p_ff <= '0;
         trav_ff    <= '0;
         radius_ff  <= sds_pkg::RADIUS_RESET;
         spacing_ff <= sds_pkg::SPACING_RESET;
      end else begin
         state_ff   <= state_in;
         first_ff   <= first_in;
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
         paint_x_ff <= paint_x_in;
         paint_y_ff <= paint_y_in;
         paint_p_ff <= paint_p_in;
         trav_ff    <= trav_in;
         radius_ff  <= radius_in;
         spacing_ff <= spacing_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      p_ff      <= p_in;
      sum_ff    <= sum_in;
      dist_ff   <= dist_in;
      step_ff   <= step_in;
      n_ff      <= n_in;
      last_ff   <= last_in;
      capped_ff <= capped_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_tdata = {2'b00, paint_p_ff[15:2], paint_y_ff, paint_x_ff};
   assign rsp_tlast = last_ff;
   assign rsp_tuser = capped_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sds_serial_unit.sv =====
// Bit-serial arithmetic unit: shift-add multiply, two-bits-a-cycle square
// root, and multiply then rounded restoring divide. Depends on sds_pkg.
`default_nettype none

module sds_serial_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  sds_pkg::sds_cmd_type cmd,
   input  logic [40:0]          arg_a,
   input  logic [19:0]          arg_b,
   input  logic [23:0]          arg_den,
   output logic                 done,
   output logic [40:0]          result
);

   sds_pkg::sds_op_type op_ff, op_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [41:0] acc_ff, acc_in;
   logic [39:0] mcand_ff, mcand_in;
   logic [19:0] mplier_ff, mplier_in;
   logic [24:0] rem_ff, rem_in;
   logic [20:0] root_ff, root_in;
   logic [23:0] den_ff, den_in;

   always_comb begin
      logic [24:0] rem_n;
      logic [24:0] trial;
      logic [24:0] part;
      logic        qbit;
      op_in     = op_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      div_in    = div_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      den_in    = den_ff;
      rem_n     = '0;
      trial     = '0;
      part      = '0;
      qbit      = 1'b0;
      if (cmd.start) begin
         op_in     = cmd.op;
         busy_in   = 1'b1;
         div_in    = 1'b0;
         rem_in    = '0;
         root_in   = '0;
         den_in    = arg_den;
         mplier_in = arg_b;
         mcand_in  = {20'd0, arg_a[19:0]};
         unique case (cmd.op)
            sds_pkg::OP_SQRT: begin
               acc_in = {1'b0, arg_a};
               cnt_in = 6'd21;
            end
            sds_pkg::OP_MULDIV: begin
               // seed with half the divisor for round half up
               acc_in = {18'd0, 1'b0, arg_den[23:1]};
               cnt_in = 6'd16;
            end
            default: begin
               acc_in = '0;
               cnt_in = 6'd20;
            end
         endcase
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 6'd1;
         unique case (op_ff)
            sds_pkg::OP_SQRT: begin
               rem_n = {rem_ff[22:0], acc_ff[41:40]};
               trial = {2'b00, root_ff, 2'b01};
               if (rem_n >= trial) begin
                  rem_in  = rem_n - trial;
                  root_in = {root_ff[19:0], 1'b1};
               end else begin
                  rem_in  = rem_n;
                  root_in = {root_ff[19:0], 1'b0};
               end
               acc_in = {acc_ff[39:0], 2'b00};
            end
            sds_pkg::OP_MULDIV: begin
               if (!div_ff) begin
                  if (mplier_ff[0]) acc_in = acc_ff + {2'b00, mcand_ff};
                  mcand_in  = {mcand_ff[38:0], 1'b0};
                  mplier_in = {1'b0, mplier_ff[19:1]};
                  if (cnt_ff == 6'd1) begin
                     div_in = 1'b1;
                     cnt_in = 6'd37;
                  end
               end else begin
                  part = {rem_ff[23:0], acc_ff[36]};
                  if (part >= {1'b0, den_ff}) begin
                     rem_in = part - {1'b0, den_ff};
                     qbit   = 1'b1;
                  end else begin
                     rem_in = part;
                  end
                  acc_in = {5'd0, acc_ff[35:0], qbit};
               end
            end
            default: begin
               if (mplier_ff[0]) acc_in = acc_ff + {2'b00, mcand_ff};
               mcand_in  = {mcand_ff[38:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[19:1]};
            end
         endcase
         if (cnt_ff == 6'd1 && !(op_ff == sds_pkg::OP_MULDIV && !div_ff)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         div_ff  <= 1'b0;
         op_ff   <= sds_pkg::OP_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         div_ff  <= div_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      den_ff    <= den_in;
   end

   always_comb begin
      unique case (op_ff)
         sds_pkg::OP_SQRT: result = {20'd0, root_ff};
         default:          result = acc_ff[40:0];
      endcase
   end

   assign done = done_ff;

endmodule

`default_nettype wire
